@@ rtl/core/sbdt_pkg.sv @@
// shared types, constants and codes for the sliding base dispatch table
package sbdt_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int REF_WIDTH   = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 32;
    localparam int HANDLE_W    = 32;
    localparam int OCC_W       = 9;

    localparam int S_DATA_W    = 96;
    localparam int M_DATA_W    = 80;

    typedef enum logic [1:0] {
        CMD_REGISTER = 2'd0,
        CMD_LOOKUP   = 2'd1,
        CMD_COUNT    = 2'd2,
        CMD_CLEAR    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_EXCEEDED = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } fsm_state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctl_cmd_t;

    typedef struct packed {
        logic out_free;
    } ctl_stat_t;

endpackage

@@ rtl/core/sbdt_ctrl.sv @@
// controller state machine: accept a word, then execute it once the output is free
module sbdt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output sbdt_pkg::ctl_cmd_t ctl_cmd,
    input  sbdt_pkg::ctl_stat_t ctl_stat
);
    import sbdt_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: begin
                if (s_tvalid) begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                if (ctl_stat.out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        ctl_cmd.load = 1'b0;
        ctl_cmd.exec = 1'b0;
        unique case (state_reg)
            FSM_IDLE: begin
                s_tready     = 1'b1;
                ctl_cmd.load = s_tvalid;
            end
            FSM_EXEC: begin
                ctl_cmd.exec = ctl_stat.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/core/sbdt_datapath.sv @@
// datapath: window registers, valid bits, handle memory and output register
module sbdt_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [1:0]                      s_tuser,
    input  logic [sbdt_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sbdt_pkg::M_DATA_W-1:0]   m_tdata,
    input  sbdt_pkg::ctl_cmd_t              ctl_cmd,
    output sbdt_pkg::ctl_stat_t             ctl_stat
);
    import sbdt_pkg::*;

    logic [2*REF_WIDTH-1:0] mem [TABLE_DEPTH];
    logic [2*REF_WIDTH-1:0] rd_reg;

    cmd_t                   op_reg;
    logic [ID_W-1:0]        id_reg;
    logic [REF_WIDTH-1:0]   an_reg;
    logic [REF_WIDTH-1:0]   di_reg;
    logic                   ge_reg;
    logic [ID_W-1:0]        off_up_reg;
    logic [ID_W-1:0]        off_dn_reg;

    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [ID_W-1:0]        base_reg, base_next;
    logic [CNT_W-1:0]       span_reg, span_next;
    logic                   empty_reg, empty_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    logic                   out_valid_reg;
    logic [M_DATA_W-1:0]    out_data_reg;

    logic [ID_W-1:0]        s_id;
    logic [ADDR_W-1:0]      s_pos;
    logic [ADDR_W-1:0]      pos;
    logic                   slot_hit;
    logic                   in_win;
    logic                   above;
    logic                   below;
    logic                   too_wide;
    logic [ID_W:0]          grown;
    logic                   do_write;
    status_t                status;
    logic                   found;
    logic [HANDLE_W-1:0]    found_an;
    logic [HANDLE_W-1:0]    found_di;

    assign s_id  = s_tdata[ID_W-1:0];
    assign s_pos = s_id[ADDR_W-1:0];
    assign pos   = id_reg[ADDR_W-1:0];

    // word capture and window offsets against the current base
    always_ff @(posedge aclk) begin
        if (ctl_cmd.load) begin
            op_reg     <= cmd_t'(s_tuser);
            id_reg     <= s_id;
            an_reg     <= REF_WIDTH'(s_tdata[2*ID_W-1:ID_W]);
            di_reg     <= REF_WIDTH'(s_tdata[3*ID_W-1:2*ID_W]);
            ge_reg     <= (s_id >= base_reg);
            off_up_reg <= s_id - base_reg;
            off_dn_reg <= base_reg - s_id;
        end
    end

    // handle memory
    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[pos] <= {di_reg, an_reg};
        end
        if (ctl_cmd.load) begin
            rd_reg <= mem[s_pos];
        end
    end

    assign slot_hit = valid_reg[pos];
    assign in_win   = (off_up_reg < ID_W'(span_reg));
    assign above    = ge_reg && !in_win;
    assign below    = !ge_reg;
    assign grown    = (ID_W+1)'(span_reg) + (ID_W+1)'(off_dn_reg);

    always_comb begin
        too_wide = 1'b0;
        if (above) begin
            too_wide = (off_up_reg >= ID_W'(TABLE_DEPTH));
        end else if (below) begin
            too_wide = (grown > (ID_W+1)'(TABLE_DEPTH));
        end
    end

    always_comb begin
        valid_next = valid_reg;
        base_next  = base_reg;
        span_next  = span_reg;
        empty_next = empty_reg;
        count_next = count_reg;
        do_write   = 1'b0;
        status     = ST_INSERTED;
        found      = 1'b0;
        found_an   = '0;
        found_di   = '0;
        if (ctl_cmd.exec) begin
            unique case (op_reg)
                CMD_REGISTER: begin
                    if (empty_reg) begin
                        base_next  = id_reg;
                        span_next  = CNT_W'(1);
                        empty_next = 1'b0;
                        do_write   = 1'b1;
                    end else if (too_wide) begin
                        status = ST_EXCEEDED;
                    end else begin
                        if (above) begin
                            span_next = CNT_W'(off_up_reg) + CNT_W'(1);
                        end else if (below) begin
                            span_next = CNT_W'(grown);
                            base_next = id_reg;
                        end
                        if (slot_hit) begin
                            status = ST_PRESENT;
                        end else begin
                            do_write = 1'b1;
                        end
                    end
                    if (do_write) begin
                        valid_next[pos] = 1'b1;
                        count_next      = count_reg + CNT_W'(1);
                    end
                end
                CMD_LOOKUP: begin
                    found = !empty_reg && in_win && slot_hit;
                    if (found) begin
                        found_an = HANDLE_W'(rd_reg[REF_WIDTH-1:0]);
                        found_di = HANDLE_W'(rd_reg[2*REF_WIDTH-1:REF_WIDTH]);
                    end
                end
                CMD_COUNT: begin
                    status = ST_INSERTED;
                end
                CMD_CLEAR: begin
                    valid_next = '0;
                    base_next  = '0;
                    span_next  = '0;
                    empty_next = 1'b1;
                    count_next = '0;
                end
                default: status = ST_INSERTED;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            base_reg  <= '0;
            span_reg  <= '0;
            empty_reg <= 1'b1;
            count_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            base_reg  <= base_next;
            span_reg  <= span_next;
            empty_reg <= empty_next;
            count_reg <= count_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl_cmd.exec) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_cmd.exec) begin
            out_data_reg <= M_DATA_W'({OCC_W'(count_next), found_di, found_an, found, status});
        end
    end

    assign m_tvalid          = out_valid_reg;
    assign m_tdata           = out_data_reg;
    assign ctl_stat.out_free = !out_valid_reg || m_tready;

endmodule

@@ rtl/core/sliding_base_dispatch_table_unit.sv @@
// top level of the sliding base dispatch table
// the result word is registered in the execute step, once the output register is free
// a new word is taken only after the last one is executed, as the handle memory read
// is followed by the update of window, valid bits and memory
// a stalled result word holds the unit in its execute step until it is taken
// reset: all slots invalid, base and span zero, table empty, count zero
module sliding_base_dispatch_table_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sbdt_pkg::S_DATA_W-1:0]   s_tdata,   // identifier, analyzer_ref, dispatcher_ref
    input  logic [1:0]                      s_tuser,   // command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sbdt_pkg::M_DATA_W-1:0]   m_tdata    // status, found, found_analyzer,
                                                       // found_dispatcher, occupied, zero pad
);
    import sbdt_pkg::*;

    ctl_cmd_t  ctl_cmd;
    ctl_stat_t ctl_stat;

    sbdt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .ctl_cmd  (ctl_cmd),
        .ctl_stat (ctl_stat)
    );

    sbdt_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .ctl_cmd  (ctl_cmd),
        .ctl_stat (ctl_stat)
    );

endmodule

@@ dv/sliding_base_dispatch_table_unit_tb.sv @@
// self-checking testbench for the sliding base dispatch table unit
module sliding_base_dispatch_table_unit_tb;
    import sbdt_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_WORDS   = 1300;

    typedef struct {
        cmd_t        cmd;
        logic [31:0] id;
        logic [31:0] an;
        logic [31:0] di;
    } table_word_t;

    typedef struct packed {
        status_t     status;
        logic        found;
        logic [31:0] an;
        logic [31:0] di;
        logic [8:0]  occ;
    } table_reply_t;

    typedef enum {RX_OPEN, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_mode_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic [1:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    table_word_t  pending_words[$];
    table_reply_t expected_replies[$];
    int           words_in    = 0;
    int           idle_cycles = 0;
    int           err_cnt     = 0;

    // shadow of the table contents
    bit           slot_live[TABLE_DEPTH];
    logic [31:0]  slot_an[TABLE_DEPTH];
    logic [31:0]  slot_di[TABLE_DEPTH];
    logic [31:0]  win_base   = '0;
    int unsigned  win_span   = 0;
    bit           tbl_empty  = 1'b1;
    int unsigned  live_count = 0;

    sliding_base_dispatch_table_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic table_reply_t table_apply(table_word_t w);
        table_reply_t r;
        bit [63:0]    top;
        bit [63:0]    grown;
        logic [31:0]  next_base;
        logic [31:0]  off;
        int           pos;
        bit           put;
        r     = '0;
        put   = 1'b0;
        pos   = w.id % TABLE_DEPTH;
        case (w.cmd)
            CMD_REGISTER: begin
                if (tbl_empty) begin
                    win_base  = w.id;
                    win_span  = 1;
                    tbl_empty = 1'b0;
                    put       = 1'b1;
                end else begin
                    next_base = win_base;
                    grown     = win_span;
                    top       = {32'd0, win_base} + win_span - 1;
                    if ({32'd0, w.id} > top) begin
                        grown = {32'd0, w.id} - {32'd0, win_base} + 1;
                    end else if (w.id < win_base) begin
                        grown     = win_span + {32'd0, win_base - w.id};
                        next_base = w.id;
                    end
                    if (grown > TABLE_DEPTH) begin
                        r.status = ST_EXCEEDED;
                    end else begin
                        win_base = next_base;
                        win_span = grown[31:0];
                        if (slot_live[pos]) begin
                            r.status = ST_PRESENT;
                        end else begin
                            put = 1'b1;
                        end
                    end
                end
                if (put) begin
                    slot_live[pos] = 1'b1;
                    slot_an[pos]   = w.an;
                    slot_di[pos]   = w.di;
                    live_count++;
                end
            end
            CMD_LOOKUP: begin
                off = w.id - win_base;
                if (!tbl_empty && off < win_span && slot_live[pos]) begin
                    r.found = 1'b1;
                    r.an    = slot_an[pos];
                    r.di    = slot_di[pos];
                end
            end
            CMD_CLEAR: begin
                foreach (slot_live[i]) slot_live[i] = 1'b0;
                win_base   = '0;
                win_span   = 0;
                tbl_empty  = 1'b1;
                live_count = 0;
            end
            default: ;
        endcase
        r.occ = live_count[8:0];
        return r;
    endfunction

    task automatic add_word(cmd_t c, logic [31:0] id, logic [31:0] an, logic [31:0] di);
        table_word_t w;
        w.cmd = c;
        w.id  = id;
        w.an  = an;
        w.di  = di;
        pending_words.push_back(w);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // sender: bursts of words with random gaps
    int burst_left    = 1;
    int gap_left      = 0;
    int words_driven  = 0;

    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || words_in != words_driven)) begin
            if (s_tvalid) begin
                words_driven = words_in;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {pending_words[0].di, pending_words[0].an, pending_words[0].id};
                s_tuser  <= pending_words[0].cmd;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern that changes mode at random intervals
    rx_mode_t rx_mode    = RX_OPEN;
    int       phase_left = 0;
    int       rx_tick    = 0;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (phase_left == 0) begin
                rx_mode    = rx_mode_t'($urandom_range(0, 3));
                phase_left = $urandom_range(16, 96);
            end
            phase_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN:     m_tready <= 1'b1;
                RX_LIGHT:    m_tready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: m_tready <= ((rx_tick % 5) < 2);
                default:     m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // monitor: predict on input accept, check on result accept
    always @(posedge aclk) begin
        table_reply_t want;
        if (aresetn) begin
            idle_cycles++;
            if (s_tvalid && s_tready) begin
                expected_replies.push_back(table_apply(pending_words[0]));
                void'(pending_words.pop_front());
                words_in++;
                idle_cycles = 0;
            end
            if (m_tvalid && m_tready) begin
                idle_cycles = 0;
                if (expected_replies.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
                end else begin
                    want = expected_replies.pop_front();
                    check_field("status", 32'(want.status), 32'(m_tdata[1:0]));
                    check_field("found", 32'(want.found), 32'(m_tdata[2]));
                    check_field("found_analyzer", want.an, m_tdata[34:3]);
                    check_field("found_dispatcher", want.di, m_tdata[66:35]);
                    check_field("occupied", 32'(want.occ), 32'(m_tdata[75:67]));
                end
            end
        end
    end

    initial begin
        logic [31:0] b;
        logic [31:0] id;
        logic [31:0] known[$];
        int          goal;
        int          pick;
        int          n_ops;
        int          stride;

        // directed words
        add_word(CMD_LOOKUP, 32'h0000_0000, '0, '0);
        add_word(CMD_COUNT, 32'hFFFF_FFFF, '1, '1);
        add_word(CMD_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        add_word(CMD_LOOKUP, 32'hFFFF_FFFF, '0, '0);
        add_word(CMD_REGISTER, 32'hFFFF_FFFF, 32'h1234_5678, 32'h9ABC_DEF0);
        add_word(CMD_REGISTER, 32'h0000_0000, 32'h1111_1111, 32'h2222_2222);
        add_word(CMD_LOOKUP, 32'h0000_0000, '0, '0);
        add_word(CMD_REGISTER, 32'hFFFF_FF00, 32'hAAAA_5555, 32'h5555_AAAA);
        add_word(CMD_REGISTER, 32'hFFFF_FEFF, 32'h3333_3333, 32'h4444_4444);
        add_word(CMD_LOOKUP, 32'hFFFF_FF00, '0, '0);
        add_word(CMD_LOOKUP, 32'hFFFF_FF01, '0, '0);
        add_word(CMD_COUNT, '0, '0, '0);
        add_word(CMD_CLEAR, '1, '1, '1);
        add_word(CMD_LOOKUP, 32'hFFFF_FFFF, '0, '0);
        add_word(CMD_REGISTER, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        add_word(CMD_REGISTER, 32'h0000_00FF, 32'hDEAD_BEEF, 32'hCAFE_F00D);
        add_word(CMD_REGISTER, 32'h0000_0100, 32'h0BAD_0BAD, 32'hFACE_FACE);
        add_word(CMD_LOOKUP, 32'h0000_0100, '0, '0);
        add_word(CMD_REGISTER, 32'hA5A5_A5A5, $urandom, $urandom);
        add_word(CMD_CLEAR, '0, '0, '0);
        add_word(CMD_REGISTER, 32'h8000_0000, $urandom, $urandom);
        add_word(CMD_REGISTER, 32'h7FFF_FFFF, $urandom, $urandom);
        add_word(CMD_LOOKUP, 32'h8000_0000, '0, '0);
        add_word(CMD_LOOKUP, 32'h7FFF_FFFF, '0, '0);
        add_word(CMD_LOOKUP, 32'h7FFF_FFFE, '0, '0);
        add_word(CMD_COUNT, '0, '0, '0);

        // random sessions: clustered windows, full fills, and noise
        goal = pending_words.size() + RANDOM_WORDS;
        while (pending_words.size() < goal) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 3))
                0:       b = $urandom;
                1:       b = $urandom_range(0, 200);
                2:       b = 32'hFFFF_FFFF - $urandom_range(0, 300);
                default: b = $urandom & 32'hFFFF_FF00;
            endcase
            if (pick < 5) begin
                add_word(CMD_CLEAR, $urandom, $urandom, $urandom);
                stride = 2 * $urandom_range(0, 127) + 1;
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    add_word(CMD_REGISTER, b + ((i * stride) % TABLE_DEPTH), $urandom, $urandom);
                end
                add_word(CMD_COUNT, $urandom, $urandom, $urandom);
                add_word(CMD_REGISTER, b + TABLE_DEPTH, $urandom, $urandom);
                add_word(CMD_REGISTER, b - 1, $urandom, $urandom);
                add_word(CMD_REGISTER, b + $urandom_range(0, 255), $urandom, $urandom);
                for (int i = 0; i < 6; i++) begin
                    add_word(CMD_LOOKUP, b + $urandom_range(0, 255), $urandom, $urandom);
                end
                add_word(CMD_LOOKUP, b + TABLE_DEPTH, $urandom, $urandom);
                add_word(CMD_LOOKUP, b - 1, $urandom, $urandom);
            end else if (pick < 70) begin
                known.delete();
                if ($urandom_range(0, 1) == 0) begin
                    add_word(CMD_CLEAR, $urandom, $urandom, $urandom);
                end
                n_ops = $urandom_range(4, 40);
                for (int i = 0; i < n_ops; i++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45) begin
                        if (known.size() != 0 && $urandom_range(0, 9) == 0) begin
                            id = known[$urandom_range(0, known.size() - 1)];
                        end else begin
                            id = b + $urandom_range(0, 300) - 40;
                            known.push_back(id);
                        end
                        add_word(CMD_REGISTER, id, $urandom, $urandom);
                    end else if (pick < 85) begin
                        if (known.size() != 0 && $urandom_range(0, 9) < 7) begin
                            id = known[$urandom_range(0, known.size() - 1)];
                        end else begin
                            id = b + $urandom_range(0, 320) - 40;
                        end
                        add_word(CMD_LOOKUP, id, $urandom, $urandom);
                    end else if (pick < 95) begin
                        add_word(CMD_COUNT, $urandom, $urandom, $urandom);
                    end else begin
                        add_word(cmd_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
                    end
                end
            end else begin
                n_ops = $urandom_range(1, 8);
                for (int i = 0; i < n_ops; i++) begin
                    add_word(cmd_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
                end
            end
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while ((pending_words.size() != 0 || expected_replies.size() != 0)
               && idle_cycles < WATCHDOG_LIMIT) begin
            @(negedge aclk);
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("sliding_base_dispatch_table_unit regression: fail");
        end else begin
            repeat (8) @(negedge aclk);
            if (err_cnt == 0) begin
                $display("sliding_base_dispatch_table_unit regression: pass");
            end else begin
                $display("sliding_base_dispatch_table_unit regression: fail");
            end
        end
        $finish;
    end

endmodule

@@ sliding_base_dispatch_table_unit.f @@
rtl/core/sbdt_pkg.sv
rtl/core/sbdt_ctrl.sv
rtl/core/sbdt_datapath.sv
rtl/core/sliding_base_dispatch_table_unit.sv
dv/sliding_base_dispatch_table_unit_tb.sv
